/* rtl/tst_pkg.sv */
// shared types, codes and constants of the timed status table
package tst_pkg;

   localparam int STATUS_SLOTS_DEFAULT = 8;

   localparam logic [31:0] STUN_CODE_RESET       = 32'h7574_7342;
   localparam logic [31:0] TIMED_LIFE_CODE_RESET = 32'h464C_5442;

   // request kind carried on tuser
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register indexes of the write port
   localparam int          CSR_IDX_W          = 1;
   localparam logic [0:0]  CSR_STUN_CODE       = 1'b0;
   localparam logic [0:0]  CSR_TIMED_LIFE_CODE = 1'b1;

   localparam int          COUNT_W   = 4;
   localparam logic [3:0]  COUNT_MAX = 4'hF;

   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 8;

   typedef struct packed {
      logic [31:0] code;
      logic [31:0] expiry;
   } entry_type;

   typedef struct packed {
      logic        wr_en;
      logic        clr_en;
      logic [31:0] code;
      logic [31:0] expiry;
   } store_cmd_type;

   typedef struct packed {
      logic code_eq;
      logic expired;
   } cmp_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_STUN,
      ST_RESP
   } state_type;

endpackage

/* rtl/tst_cmp.sv */
// shared compare unit: code match and expiry test for one slot
module tst_cmp (
   input  logic [31:0]             key,
   input  logic [31:0]             now_ms,
   input  tst_pkg::entry_type      entry,
   output tst_pkg::cmp_result_type result
);

   always_comb begin
      result.code_eq = (entry.code == key);
      // permanent entries (zero expiry) never time out
      result.expired = (entry.expiry != 32'd0) && (now_ms >= entry.expiry);
   end

endmodule

/* rtl/tst_store.sv */
// slot storage: code/expiry memory with registered read and live bits
module tst_store #(
   parameter int STATUS_SLOTS = tst_pkg::STATUS_SLOTS_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic [((STATUS_SLOTS > 1) ? $clog2(STATUS_SLOTS) : 1)-1:0] rd_addr,
   output tst_pkg::entry_type                                 rd_data,
   output logic [STATUS_SLOTS-1:0]                            live,
   input  logic [((STATUS_SLOTS > 1) ? $clog2(STATUS_SLOTS) : 1)-1:0] wr_addr,
   input  tst_pkg::store_cmd_type                             cmd
);

   tst_pkg::entry_type        entry_mem_ff [STATUS_SLOTS];
   tst_pkg::entry_type        rd_data_ff;
   logic [STATUS_SLOTS-1:0]   live_ff;
   logic [STATUS_SLOTS-1:0]   live_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem_ff[wr_addr] <= '{code: cmd.code, expiry: cmd.expiry};
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_comb begin
      live_in = live_ff;
      if (cmd.wr_en) begin
         live_in[wr_addr] = 1'b1;
      end else if (cmd.clr_en) begin
         live_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign live    = live_ff;

endmodule

/* rtl/timed_status_table.sv */
// top level of the timed status table: sequencer, registers and stream ports
//
// A table of STATUS_SLOTS status entries (code, expiry time, live bit). An add
// transfer refreshes the live entry with the same code or else takes the
// lowest free slot; adds with a zero level or a zero low code byte are dropped
// at once. A tick transfer clears every live entry whose non-zero expiry is not
// later than now_ms (plain unsigned compare, no wrap handling). When anything
// changed, a second pass over the slots rebuilds the stunned flag. Each request
// gives exactly one response transfer. The slots sit in a memory with one
// registered read port and are visited one per cycle through a single compare
// unit, so the read port sets the pace: a dropped add goes straight to its
// response, a tick that clears nothing or an add that finds no slot makes one
// pass over the slots, a tick that clears something two passes and an accepted
// add two passes with a write step between; the response transfer may wait on
// rsp_tready. No request is taken while one is in progress. Changing stun_code
// does not rebuild the flag by itself. The two code registers may be written
// at any time through the csr port and reset to the stun and timed-life codes.
module timed_status_table #(
   parameter int STATUS_SLOTS = tst_pkg::STATUS_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // from bit 0: status_code[31:0], status_level[15:0], duration_ms[31:0],
   // now_ms[31:0], unit_dead, zero fill to 120 bits
   input  logic [tst_pkg::REQ_TDATA_W-1:0] req_tdata,
   // operation (0 add, 1 tick)
   input  logic                            req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // from bit 0: accepted, stunned, kill_unit, expired_count[3:0], zero fill
   output logic [tst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register write port
   input  logic                            csr_we,
   input  logic [tst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam int IDX_W = (STATUS_SLOTS > 1) ? $clog2(STATUS_SLOTS) : 1;
   localparam int CNT_W = $clog2(STATUS_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(STATUS_SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(STATUS_SLOTS - 1);

   // request fields
   logic [31:0] req_code;
   logic [15:0] req_level;
   logic [31:0] req_duration;
   logic [31:0] req_now;
   logic        req_dead;
   logic        req_xfer;
   logic        add_ok;

   assign req_code     = req_tdata[31:0];
   assign req_level    = req_tdata[47:32];
   assign req_duration = req_tdata[79:48];
   assign req_now      = req_tdata[111:80];
   assign req_dead     = req_tdata[112];

   // state and registers
   tst_pkg::state_type state_ff, state_in;

   logic [31:0]                 stun_code_ff, stun_code_in;
   logic [31:0]                 life_code_ff, life_code_in;
   logic                        op_ff, op_in;
   logic [31:0]                 code_ff, code_in;
   logic [31:0]                 dur_ff, dur_in;
   logic [31:0]                 now_ff, now_in;
   logic                        dead_ff, dead_in;
   logic [CNT_W-1:0]            rd_cnt_ff, rd_cnt_in;
   logic                        rvld_ff, rvld_in;
   logic [IDX_W-1:0]            ridx_ff, ridx_in;
   logic                        match_found_ff, match_found_in;
   logic [IDX_W-1:0]            match_idx_ff, match_idx_in;
   logic                        free_found_ff, free_found_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic                        changed_ff, changed_in;
   logic                        lethal_ff, lethal_in;
   logic [tst_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        stun_acc_ff, stun_acc_in;
   logic                        stun_flag_ff, stun_flag_in;
   logic                        accepted_ff, accepted_in;

   // store and compare unit hookup
   logic [IDX_W-1:0]            rd_addr;
   logic [IDX_W-1:0]            wr_addr;
   tst_pkg::entry_type          rd_data;
   logic [STATUS_SLOTS-1:0]     live;
   tst_pkg::store_cmd_type      cmd;
   logic [31:0]                 cmp_key;
   tst_pkg::cmp_result_type     cmp;

   logic issue;
   logic slot_live;
   logic scan_last;

   tst_store #(
      .STATUS_SLOTS (STATUS_SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .live    (live),
      .wr_addr (wr_addr),
      .cmd     (cmd)
   );

   tst_cmp u_cmp (
      .key    (cmp_key),
      .now_ms (now_ff),
      .entry  (rd_data),
      .result (cmp)
   );

   // only idle takes a request
   assign req_tready = (state_ff == tst_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign add_ok     = (req_level != 16'd0) && (req_code[7:0] != 8'd0);
   assign issue      = ((state_ff == tst_pkg::ST_SCAN) || (state_ff == tst_pkg::ST_STUN))
                       && (rd_cnt_ff < SLOT_COUNT);
   assign rd_addr    = rd_cnt_ff[IDX_W-1:0];
   assign slot_live  = live[ridx_ff];
   // the slot whose data comes back this cycle is the last one of the pass
   assign scan_last  = rvld_ff && (ridx_ff == LAST_SLOT);

   // the one compare unit looks for the request code on an add, the
   // timed-life code on a tick and the stun code while rebuilding the flag
   always_comb begin
      if (state_ff == tst_pkg::ST_STUN) begin
         cmp_key = stun_code_ff;
      end else if (op_ff == tst_pkg::OP_TICK) begin
         cmp_key = life_code_ff;
      end else begin
         cmp_key = code_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tst_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if ((req_tuser == tst_pkg::OP_TICK) || add_ok) begin
                  state_in = tst_pkg::ST_SCAN;
               end else begin
                  state_in = tst_pkg::ST_RESP;
               end
            end
         end
         tst_pkg::ST_SCAN: begin
            if (scan_last) begin
               if (op_ff == tst_pkg::OP_TICK) begin
                  state_in = changed_in ? tst_pkg::ST_STUN : tst_pkg::ST_RESP;
               end else begin
                  state_in = (match_found_in || free_found_in) ? tst_pkg::ST_WRITE
                                                               : tst_pkg::ST_RESP;
               end
            end
         end
         tst_pkg::ST_WRITE: begin
            state_in = tst_pkg::ST_STUN;
         end
         tst_pkg::ST_STUN: begin
            if (scan_last) begin
               state_in = tst_pkg::ST_RESP;
            end
         end
         tst_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = tst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tst_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      stun_code_in   = stun_code_ff;
      life_code_in   = life_code_ff;
      op_in          = op_ff;
      code_in        = code_ff;
      dur_in         = dur_ff;
      now_in         = now_ff;
      dead_in        = dead_ff;
      rd_cnt_in      = rd_cnt_ff;
      rvld_in        = issue;
      ridx_in        = rd_cnt_ff[IDX_W-1:0];
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      changed_in     = changed_ff;
      lethal_in      = lethal_ff;
      count_in       = count_ff;
      stun_acc_in    = stun_acc_ff;
      stun_flag_in   = stun_flag_ff;
      accepted_in    = accepted_ff;
      cmd            = '0;
      wr_addr        = ridx_ff;
      rsp_tvalid     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            tst_pkg::CSR_STUN_CODE:       stun_code_in = csr_wdata;
            tst_pkg::CSR_TIMED_LIFE_CODE: life_code_in = csr_wdata;
            default: ;
         endcase
      end

      // read counter: steps per issued read, back to zero between passes
      if (issue) begin
         rd_cnt_in = rd_cnt_ff + CNT_W'(1);
      end else begin
         rd_cnt_in = '0;
      end

      case (state_ff)
         tst_pkg::ST_IDLE: begin
            if (req_xfer) begin
               op_in          = req_tuser;
               code_in        = req_code;
               dur_in         = req_duration;
               now_in         = req_now;
               dead_in        = req_dead;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               changed_in     = 1'b0;
               lethal_in      = 1'b0;
               count_in       = '0;
               stun_acc_in    = 1'b0;
               accepted_in    = 1'b0;
            end
         end
         tst_pkg::ST_SCAN: begin
            if (rvld_ff) begin
               if (op_ff == tst_pkg::OP_TICK) begin
                  if (slot_live && cmp.expired) begin
                     cmd.clr_en = 1'b1;
                     changed_in = 1'b1;
                     if (cmp.code_eq) begin
                        lethal_in = 1'b1;
                     end
                     if (count_ff != tst_pkg::COUNT_MAX) begin
                        count_in = count_ff + tst_pkg::COUNT_W'(1);
                     end
                  end
               end else begin
                  // a live entry with the same code beats any free slot
                  if (slot_live && cmp.code_eq && !match_found_ff) begin
                     match_found_in = 1'b1;
                     match_idx_in   = ridx_ff;
                  end
                  if (!slot_live && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = ridx_ff;
                  end
               end
            end
         end
         tst_pkg::ST_WRITE: begin
            cmd.wr_en   = 1'b1;
            cmd.code    = code_ff;
            // a sum that wraps to zero makes the entry permanent, as does zero duration
            cmd.expiry  = (dur_ff == 32'd0) ? 32'd0 : now_ff + dur_ff;
            wr_addr     = match_found_ff ? match_idx_ff : free_idx_ff;
            accepted_in = 1'b1;
         end
         tst_pkg::ST_STUN: begin
            if (rvld_ff) begin
               stun_acc_in = stun_acc_ff || (slot_live && cmp.code_eq);
               if (scan_last) begin
                  stun_flag_in = stun_acc_in;
               end
            end
         end
         tst_pkg::ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {1'b0, count_ff, lethal_ff && !dead_ff, stun_flag_ff, accepted_ff};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tst_pkg::ST_IDLE;
         stun_code_ff <= tst_pkg::STUN_CODE_RESET;
         life_code_ff <= tst_pkg::TIMED_LIFE_CODE_RESET;
         rd_cnt_ff    <= '0;
         rvld_ff      <= 1'b0;
         stun_flag_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stun_code_ff <= stun_code_in;
         life_code_ff <= life_code_in;
         rd_cnt_ff    <= rd_cnt_in;
         rvld_ff      <= rvld_in;
         stun_flag_ff <= stun_flag_in;
      end
   end

   // payload and per-request working registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      code_ff        <= code_in;
      dur_ff         <= dur_in;
      now_ff         <= now_in;
      dead_ff        <= dead_in;
      ridx_ff        <= ridx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      changed_ff     <= changed_in;
      lethal_ff      <= lethal_in;
      count_ff       <= count_in;
      stun_acc_ff    <= stun_acc_in;
      accepted_ff    <= accepted_in;
   end

endmodule

/* sim/testbench.sv */
// testbench of the timed status table: directed and random request streams checked on the fly
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS           = tst_pkg::STATUS_SLOTS_DEFAULT;
   // sized above the worst case for one request, so this covers anything still in flight
   localparam int SETTLE_CYCLES   = 2 * SLOTS + 8;
   // cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT     = 4000;
   // long receiver hold-off so the block sits on a finished response
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PRESSURE_EVERY  = 700;
   localparam int PRESSURE_AT     = 350;
   localparam int PHASE_ITEMS     = 320;
   localparam int PHASES          = 6;
   localparam int POOL_SIZE       = 16;

   // request fields as packed on req_tdata, first field in the lowest bits
   typedef struct packed {
      logic        dead;
      logic [31:0] now;
      logic [31:0] dur;
      logic [15:0] level;
      logic [31:0] code;
   } req_fields_type;

   typedef struct {
      logic           op;
      req_fields_type f;
   } status_req_type;

   // response fields as packed on rsp_tdata, accepted in bit 0
   typedef struct packed {
      logic [3:0] expired_count;
      logic       kill_unit;
      logic       stunned;
      logic       accepted;
   } status_rsp_type;

   localparam int FIELDS_W = $bits(req_fields_type);
   localparam int RSP_W    = $bits(status_rsp_type);

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tst_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = tst_pkg::OP_ADD;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tst_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [tst_pkg::CSR_IDX_W-1:0]   csr_index = tst_pkg::CSR_STUN_CODE;
   logic [31:0]                     csr_wdata = '0;

   // behavioural copy of the table and its code registers
   logic [31:0] tbl_code   [SLOTS];
   logic [15:0] tbl_level  [SLOTS];
   logic [31:0] tbl_expiry [SLOTS];
   logic        tbl_stun;
   logic [31:0] cfg_stun_code;
   logic [31:0] cfg_life_code;

   status_req_type req_backlog[$];     // requests waiting for the driver
   status_rsp_type due_responses[$];   // predicted responses, oldest first
   status_rsp_type want_rsp;
   status_rsp_type got_rsp;
   status_req_type req_next;

   int unsigned req_queued = 0;
   int unsigned req_taken = 0;
   int unsigned rsp_seen = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;

   // transfer flags from the last rising edge, read by the drivers at the falling edge
   logic req_xfer = 1'b0;
   logic rsp_xfer = 1'b0;

   int unsigned req_gap = 0;
   int unsigned req_run_left = 0;
   bit          req_run_calm = 1'b0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_run_left = 0;
   bit          rsp_run_calm = 1'b0;

   logic [31:0] code_pool [POOL_SIZE];
   logic [31:0] sim_now = 32'd100;

   timed_status_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stunned flag: any live slot holding the stun code
   function automatic void refresh_stun();
      tbl_stun = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         if (tbl_level[s] != 16'd0 && tbl_code[s] == cfg_stun_code) begin
            tbl_stun = 1'b1;
         end
      end
   endfunction

   // applies one request to the table copy and returns the response it should give
   function automatic status_rsp_type step_status_table(logic op, req_fields_type f);
      status_rsp_type rs;
      logic           hit;
      int             pick;
      logic           lethal;
      logic           changed;
      rs = '0;
      if (op == tst_pkg::OP_ADD) begin
         if (f.level != 16'd0 && f.code[7:0] != 8'd0) begin
            hit = 1'b0;
            pick = 0;
            for (int s = 0; s < SLOTS; s++) begin
               // a live entry with the same code wins over any earlier free slot
               if (tbl_level[s] != 16'd0 && tbl_code[s] == f.code) begin
                  pick = s;
                  hit = 1'b1;
                  break;
               end
               if (tbl_level[s] == 16'd0 && !hit) begin
                  pick = s;
                  hit = 1'b1;
               end
            end
            if (hit) begin
               tbl_code[pick] = f.code;
               tbl_level[pick] = f.level;
               // wraps at 32 bits; a sum of exactly zero leaves the entry permanent
               tbl_expiry[pick] = (f.dur != 32'd0) ? f.now + f.dur : 32'd0;
               refresh_stun();
               rs.accepted = 1'b1;
            end
         end
      end else begin
         lethal = 1'b0;
         changed = 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            // plain unsigned compare, no allowance for the clock wrapping
            if (tbl_level[s] != 16'd0 && tbl_expiry[s] != 32'd0 && f.now >= tbl_expiry[s]) begin
               if (tbl_code[s] == cfg_life_code) begin
                  lethal = 1'b1;
               end
               tbl_code[s] = '0;
               tbl_level[s] = '0;
               tbl_expiry[s] = '0;
               changed = 1'b1;
               if (rs.expired_count != tst_pkg::COUNT_MAX) begin
                  rs.expired_count = rs.expired_count + 4'd1;
               end
            end
         end
         if (changed) begin
            refresh_stun();
         end
         rs.kill_unit = lethal && !f.dead;
      end
      rs.stunned = tbl_stun;
      return rs;
   endfunction

   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // idle length after a transfer: calm stretches with none, otherwise mostly short
   function automatic int unsigned next_gap(inout int unsigned run_left, inout bit run_calm);
      int unsigned r;
      if (run_left == 0) begin
         run_left = $urandom_range(10, 120);
         run_calm = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      if (run_calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 92) begin
         return $urandom_range(4, 15);
      end else if (r < 97) begin
         return $urandom_range(16, 30);
      end
      return $urandom_range(31, 90);
   endfunction

   // mostly well-formed adds and ticks on a running clock, the rest malformed or pure noise
   function automatic status_req_type random_status_req();
      status_req_type rq;
      int unsigned    kind;
      kind = $urandom_range(0, 99);
      rq.op = tst_pkg::OP_ADD;
      rq.f.code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
      rq.f.level = 16'($urandom_range(1, 16'hFFFF));
      rq.f.dur = 32'($urandom_range(1, 300));
      rq.f.dead = 1'($urandom);
      sim_now = sim_now + 32'($urandom_range(0, 25));
      rq.f.now = sim_now;
      if (kind < 50) begin
         case ($urandom_range(0, 9))
            0: begin
               rq.f.dur = 32'd0;
            end
            1: begin
               rq.f.dur = $urandom;
            end
            2, 3: begin
               rq.f.dur = 32'($urandom_range(1000, 5000));
            end
            default: begin
            end
         endcase
         if ($urandom_range(0, 19) == 0) begin
            rq.f.code = $urandom;
         end
         if ($urandom_range(0, 19) == 0) begin
            rq.f.level = 16'hFFFF;
         end
      end else if (kind < 88) begin
         rq.op = tst_pkg::OP_TICK;
         if ($urandom_range(0, 29) == 0) begin
            // big jump forward flushes most of the table at once
            sim_now = sim_now + 32'($urandom_range(500, 6000));
            rq.f.now = sim_now;
         end else if ($urandom_range(0, 39) == 0) begin
            rq.f.now = $urandom;
         end
      end else if (kind < 94) begin
         // rejected add: zero level or zero first character
         if ($urandom_range(0, 1) == 0) begin
            rq.f.level = 16'd0;
         end else begin
            rq.f.code[7:0] = 8'd0;
         end
      end else begin
         rq.op = 1'($urandom);
         rq.f.code = $urandom;
         rq.f.level = 16'($urandom);
         rq.f.dur = $urandom;
         rq.f.now = $urandom;
      end
      return rq;
   endfunction

   task automatic push_request(input status_req_type rq);
      req_backlog.push_back(rq);
      req_queued++;
   endtask

   task automatic push_add(input logic [31:0] code, input logic [15:0] level,
                           input logic [31:0] dur, input logic [31:0] now);
      status_req_type rq;
      rq.op = tst_pkg::OP_ADD;
      rq.f = '{dead: 1'($urandom), now: now, dur: dur, level: level, code: code};
      push_request(rq);
   endtask

   task automatic push_tick(input logic [31:0] now, input logic dead);
      status_req_type rq;
      rq.op = tst_pkg::OP_TICK;
      rq.f = '{dead: dead, now: now, dur: $urandom, level: 16'($urandom), code: $urandom};
      push_request(rq);
   endtask

   // wait until every request has been taken and answered, then let the block settle
   task automatic wait_drained();
      do @(negedge clock);
      while (req_taken != req_queued || due_responses.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // writes both code registers on back-to-back cycles, called at a falling edge
   task automatic write_codes(input logic [31:0] stun, input logic [31:0] life);
      csr_we <= 1'b1;
      csr_index <= tst_pkg::CSR_STUN_CODE;
      csr_wdata <= stun;
      @(negedge clock);
      csr_index <= tst_pkg::CSR_TIMED_LIFE_CODE;
      csr_wdata <= life;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver: holds each item until its transfer, then idles a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_xfer) begin
         if (req_gap != 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_next = req_backlog.pop_front();
            req_tuser <= req_next.op;
            req_tdata <= {{(tst_pkg::REQ_TDATA_W - FIELDS_W){1'b0}}, req_next.f};
            req_tvalid <= 1'b1;
            req_gap = next_gap(req_run_left, req_run_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side: random stalls after each transfer, now and then a long hold-off
   // while the sender keeps offering, so the block has to stall its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_xfer) begin
            rsp_stall = (rsp_seen % PRESSURE_EVERY == PRESSURE_AT) ?
                        HOLD_OFF_CYCLES : next_gap(rsp_run_left, rsp_run_calm);
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: register writes, request transfers into the predictor, response checks
   always @(posedge clock) begin
      req_xfer <= req_tvalid && req_tready;
      rsp_xfer <= rsp_tvalid && rsp_tready;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            tbl_code[s] = '0;
            tbl_level[s] = '0;
            tbl_expiry[s] = '0;
         end
         tbl_stun = 1'b0;
         cfg_stun_code = tst_pkg::STUN_CODE_RESET;
         cfg_life_code = tst_pkg::TIMED_LIFE_CODE_RESET;
      end else begin
         // a register write leaves the stunned flag alone
         if (csr_we) begin
            case (csr_index)
               tst_pkg::CSR_STUN_CODE: begin
                  cfg_stun_code = csr_wdata;
               end
               tst_pkg::CSR_TIMED_LIFE_CODE: begin
                  cfg_life_code = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            due_responses.push_back(
               step_status_table(req_tuser, req_fields_type'(req_tdata[FIELDS_W-1:0])));
            req_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            got_rsp = status_rsp_type'(rsp_tdata[RSP_W-1:0]);
            if (due_responses.size() == 0) begin
               $error("response transfer with nothing outstanding: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want_rsp = due_responses.pop_front();
               check_field("accepted", 4'(want_rsp.accepted), 4'(got_rsp.accepted));
               check_field("stunned", 4'(want_rsp.stunned), 4'(got_rsp.stunned));
               check_field("kill_unit", 4'(want_rsp.kill_unit), 4'(got_rsp.kill_unit));
               check_field("expired_count", want_rsp.expired_count, got_rsp.expired_count);
            end
         end
         // watchdog on cycles with no transfer on either stream
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // stimulus sequencer
   initial begin
      logic [31:0] shared_code;
      // codes used by the directed part, the extremes, and a few random ones
      code_pool[0]  = tst_pkg::STUN_CODE_RESET;
      code_pool[1]  = tst_pkg::TIMED_LIFE_CODE_RESET;
      code_pool[2]  = 32'h0000_00A1;
      code_pool[3]  = 32'h0000_00B1;
      code_pool[4]  = 32'h0000_00B2;
      code_pool[5]  = 32'h0000_00B3;
      code_pool[6]  = 32'h0000_00B4;
      code_pool[7]  = 32'h0000_00B5;
      code_pool[8]  = 32'h0000_00B6;
      code_pool[9]  = 32'h0000_00D1;
      code_pool[10] = 32'hFFFF_FFFF;
      code_pool[11] = 32'h0000_0001;
      for (int i = 12; i < POOL_SIZE; i++) begin
         code_pool[i] = $urandom | 32'h1;
      end

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed part with the codes as they come out of reset
      @(posedge clock);
      push_add(32'h1122_3344, 16'd0, 32'd10, 32'd100);                 // zero level, dropped
      push_add(32'h1122_3300, 16'd5, 32'd10, 32'd100);                 // zero first character
      push_add(tst_pkg::STUN_CODE_RESET, 16'hFFFF, 32'd0, 32'd100);    // permanent stun
      push_add(tst_pkg::TIMED_LIFE_CODE_RESET, 16'd1, 32'd50, 32'd100);
      push_tick(32'd149, 1'b0);                                        // one short of expiry
      push_tick(32'd150, 1'b0);                                        // timed life ends, kill
      push_add(32'h0000_00A1, 16'd2, 32'h10, 32'hFFFF_FFF0);           // wraps to exactly zero
      push_add(tst_pkg::TIMED_LIFE_CODE_RESET, 16'd3, 32'h200, 32'hFFFF_FF00);
      push_tick(32'h50, 1'b1);                                 // wrapped expiry still ahead
      push_tick(32'hFFFF_FFFF, 1'b1);                          // expires, unit already dead
      for (int i = 0; i < 6; i++) begin
         push_add(32'h0000_00B1 + i, 16'd7, 32'd1000, 32'd1000);
      end
      push_add(32'h0000_00C1, 16'd4, 32'd10, 32'd1000);        // table full
      push_add(32'h0000_00B6, 16'd9, 32'd2000, 32'd1000);      // refresh on a full table
      push_tick(32'd2000, 1'b0);                               // several at once
      push_add(32'h0000_00B6, 16'd1, 32'd0, 32'd2100);         // refresh past free slots
      push_add(tst_pkg::STUN_CODE_RESET, 16'd8, 32'd5, 32'd2100);
      push_tick(32'd2200, 1'b0);                               // stun drops
      wait_drained();

      // new stun code is already live but the flag only moves on the next change
      write_codes(32'h0000_00B6, 32'h0000_00A1);
      @(posedge clock);
      push_add(32'h0000_0055, 16'd0, 32'd1, 32'd2300);
      push_add(32'h0000_00D1, 16'd1, 32'd0, 32'd2300);
      push_add(32'h0000_00A1, 16'd6, 32'd1, 32'd2300);
      push_tick(32'd2301, 1'b0);
      wait_drained();

      // random phases, each under its own pair of codes
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               write_codes(32'h0000_0000, 32'hFFFF_FFFF);
            end
            1: begin
               write_codes(32'hFFFF_FFFF, 32'h0000_0000);
            end
            2: begin
               write_codes(code_pool[$urandom_range(0, POOL_SIZE - 1)],
                           code_pool[$urandom_range(0, POOL_SIZE - 1)]);
               sim_now = 32'hFFFF_F000;  // run the clock through its wrap
            end
            3: begin
               write_codes($urandom, $urandom);
            end
            4: begin
               write_codes(tst_pkg::STUN_CODE_RESET, tst_pkg::TIMED_LIFE_CODE_RESET);
            end
            default: begin
               shared_code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
               write_codes(shared_code, shared_code);
            end
         endcase
         @(posedge clock);
         repeat (PHASE_ITEMS) push_request(random_status_req());
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
